[rtl/iirdf1_pkg.sv]
// Shared types and constants for the direct form I IIR filter core.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

    localparam int DATA_W    = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TAP_CNT_W = 2;
    localparam int NUM_COEF  = 3;           // coefficients per direction in the register map
    localparam int MAC_TERMS = 5;           // three feed-forward slots, two feedback slots
    localparam int PROD_W    = DATA_W + COEF_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int MAG_W     = ACC_W - 1;
    localparam int QUO_W     = DATA_W + 1;  // quotient magnitude bits kept by the divider
    localparam int CNT_W     = $clog2(QUO_W);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_FEED_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_TAPS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_TAPS = 3'd7;

    localparam logic [COEF_W-1:0]    COEF_UNITY    = 16'h4000;
    localparam logic [TAP_CNT_W-1:0] TAPS_RESET    = 2'd3;

    typedef struct packed {
        logic [NUM_COEF-1:0][COEF_W-1:0] feed_coef;
        logic [NUM_COEF-1:0][COEF_W-1:0] back_coef;
        logic [TAP_CNT_W-1:0]            feed_taps;
        logic [TAP_CNT_W-1:0]            back_taps;
    } cfg_t;

    typedef struct packed {
        logic                 load;       // take the input beat, clear the accumulator
        logic                 mul_en;     // multiply the selected term
        logic                 term_feed;  // 1: feed-forward term, 0: feedback term
        logic [1:0]           term_idx;   // coefficient index of the term
        logic                 prep;       // form magnitudes and overflow check
        logic                 div_step;   // one restoring division step
        logic                 finish;     // saturate, load output, push output history
    } cmd_t;

endpackage

`default_nettype wire

[rtl/iirdf1_regs.sv]
// Configuration register file for the IIR filter core.
// Depends on iirdf1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [iirdf1_pkg::COEF_W-1:0]       cfg_data,
    output iirdf1_pkg::cfg_t                         cfg
);

    iirdf1_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.feed_coef[0] <= iirdf1_pkg::COEF_UNITY;
            cfg_reg.back_coef[0] <= iirdf1_pkg::COEF_UNITY;
            cfg_reg.feed_taps    <= iirdf1_pkg::TAPS_RESET;
            cfg_reg.back_taps    <= iirdf1_pkg::TAPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                iirdf1_pkg::REG_FEED_0:    cfg_reg.feed_coef[0] <= cfg_data;
                iirdf1_pkg::REG_FEED_1:    cfg_reg.feed_coef[1] <= cfg_data;
                iirdf1_pkg::REG_FEED_2:    cfg_reg.feed_coef[2] <= cfg_data;
                iirdf1_pkg::REG_BACK_0:    cfg_reg.back_coef[0] <= cfg_data;
                iirdf1_pkg::REG_BACK_1:    cfg_reg.back_coef[1] <= cfg_data;
                iirdf1_pkg::REG_BACK_2:    cfg_reg.back_coef[2] <= cfg_data;
                iirdf1_pkg::REG_FEED_TAPS:
                    cfg_reg.feed_taps <= cfg_data[iirdf1_pkg::TAP_CNT_W-1:0];
                iirdf1_pkg::REG_BACK_TAPS:
                    cfg_reg.back_taps <= cfg_data[iirdf1_pkg::TAP_CNT_W-1:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/iirdf1_ctrl.sv]
// Sequencer for the IIR filter core: handshakes, MAC schedule, divider steps.
// Depends on iirdf1_pkg; drives iirdf1_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_ctrl #(
    parameter int TAPS = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire iirdf1_pkg::cfg_t    cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output iirdf1_pkg::cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    localparam logic [1:0] TAPS_MAX = 2'(TAPS);

    state_t                          state_reg, state_next;
    logic [iirdf1_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [1:0]                      nf, nb;
    logic [1:0]                      idx;
    logic                            feed;
    logic                            used;

    function automatic logic [1:0] clamp_taps(input logic [1:0] v);
        logic [1:0] n;
        n = v;
        if (n == 2'd0)
            n = 2'd1;
        if (n > TAPS_MAX)
            n = TAPS_MAX;
        return n;
    endfunction

    assign nf = clamp_taps(cfg.feed_taps);
    assign nb = clamp_taps(cfg.back_taps);

    // slots 0..2 are feed-forward taps 0..2, slots 3..4 are feedback taps 1..2
    always_comb
    begin
        if (cnt_reg < iirdf1_pkg::CNT_W'(iirdf1_pkg::NUM_COEF))
        begin
            feed = 1'b1;
            idx  = cnt_reg[1:0];
            used = (idx < nf);
        end
        else
        begin
            feed = 1'b0;
            idx  = 2'(cnt_reg - iirdf1_pkg::CNT_W'(2));
            used = (idx < nb);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = in_valid && in_ready;
        cmd.mul_en    = (state_reg == ST_MAC) && used;
        cmd.term_feed = feed;
        cmd.term_idx  = idx;
        cmd.prep      = (state_reg == ST_PREP);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.finish    = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cmd.load)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == iirdf1_pkg::CNT_W'(iirdf1_pkg::MAC_TERMS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_PREP;
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == iirdf1_pkg::CNT_W'(iirdf1_pkg::QUO_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
                if (cmd.finish)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MAC))
        else $error("accepted beat did not start the MAC sequence");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < iirdf1_pkg::CNT_W'(iirdf1_pkg::QUO_W)))
        else $error("divider step count out of range");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == iirdf1_pkg::CNT_W'(iirdf1_pkg::QUO_W - 1))
        |=> (state_reg == ST_FIN))
        else $error("divider did not hand over to finish");

    a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

[rtl/iirdf1_datapath.sv]
// Datapath for the IIR filter core: histories, shared multiplier, accumulator,
// restoring divider, saturation and result register. Depends on iirdf1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_datapath #(
    parameter int TAPS = 3
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire iirdf1_pkg::cfg_t                       cfg,
    input  wire iirdf1_pkg::cmd_t                       cmd,
    input  wire logic signed [iirdf1_pkg::DATA_W-1:0]   sample_in,
    output logic signed [iirdf1_pkg::DATA_W-1:0]        sample_out,
    output logic                                        saturated,
    output logic                                        bad_divisor
);

    localparam int DW = iirdf1_pkg::DATA_W;
    localparam int CW = iirdf1_pkg::COEF_W;
    localparam int PW = iirdf1_pkg::PROD_W;
    localparam int AW = iirdf1_pkg::ACC_W;
    localparam int MW = iirdf1_pkg::MAG_W;
    localparam int QW = iirdf1_pkg::QUO_W;

    localparam logic [QW-1:0]        POS_LIMIT = QW'(32767);
    localparam logic [QW-1:0]        NEG_LIMIT = QW'(32768);
    localparam logic signed [DW-1:0] SAT_HI    = 16'sh7FFF;
    localparam logic signed [DW-1:0] SAT_LO    = 16'sh8000;

    logic signed [DW-1:0]  x_hist_reg [TAPS];
    logic signed [DW-1:0]  y_hist_reg [TAPS];
    logic signed [PW-1:0]  product_reg;
    logic                  neg_term_reg;
    logic                  acc_en_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [DW-1:0]         rem_reg;
    logic [QW-1:0]         quo_reg;
    logic [DW-1:0]         dmag_reg;
    logic                  neg_q_reg;
    logic                  ovf_reg;
    logic                  zero_div_reg;
    logic signed [DW-1:0]  sample_out_reg;
    logic                  saturated_reg;
    logic                  bad_divisor_reg;

    logic signed [DW-1:0]  opnd;
    logic signed [CW-1:0]  coef;
    logic signed [CW-1:0]  divisor;
    logic [MW-1:0]         acc_mag;
    logic [DW-1:0]         d_mag;
    logic [DW:0]           rem_shift;
    logic                  rem_ge;
    logic [DW:0]           rem_diff;
    logic signed [DW-1:0]  y;
    logic                  sat;

    // operand select: feedback tap k reads output history entry k-1
    always_comb
    begin
        opnd = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            if (cmd.term_feed && cmd.term_idx == 2'(i))
                opnd = x_hist_reg[i];
            if (!cmd.term_feed && cmd.term_idx == 2'(i + 1))
                opnd = y_hist_reg[i];
        end
    end

    always_comb
    begin
        case (cmd.term_idx)
            2'd0:    coef = cmd.term_feed ? cfg.feed_coef[0] : cfg.back_coef[0];
            2'd1:    coef = cmd.term_feed ? cfg.feed_coef[1] : cfg.back_coef[1];
            2'd2:    coef = cmd.term_feed ? cfg.feed_coef[2] : cfg.back_coef[2];
            default: coef = '0;
        endcase
    end

    assign divisor  = cfg.back_coef[0];
    assign acc_mag  = acc_reg[AW-1] ? MW'(-acc_reg) : MW'(acc_reg);
    assign d_mag    = divisor[CW-1] ? DW'(-divisor) : DW'(divisor);

    assign rem_shift = {rem_reg, quo_reg[QW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dmag_reg});
    assign rem_diff  = rem_shift - {1'b0, dmag_reg};

    always_comb
    begin
        sat = 1'b0;
        y   = '0;
        if (zero_div_reg)
        begin
            y = '0;
        end
        else if (ovf_reg)
        begin
            sat = 1'b1;
            y   = neg_q_reg ? SAT_LO : SAT_HI;
        end
        else if (!neg_q_reg)
        begin
            if (quo_reg > POS_LIMIT)
            begin
                sat = 1'b1;
                y   = SAT_HI;
            end
            else
                y = quo_reg[DW-1:0];
        end
        else
        begin
            if (quo_reg > NEG_LIMIT)
            begin
                sat = 1'b1;
                y   = SAT_LO;
            end
            else
                y = DW'(-quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.mul_en;
            if (cmd.load)
            begin
                x_hist_reg[0] <= sample_in;
                for (int i = 1; i < TAPS; i++)
                    x_hist_reg[i] <= x_hist_reg[i - 1];
            end
            if (cmd.finish)
            begin
                y_hist_reg[0] <= y;
                for (int i = 1; i < TAPS; i++)
                    y_hist_reg[i] <= y_hist_reg[i - 1];
            end
        end
    end

    // register the product, accumulate it in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            product_reg  <= coef * opnd;
            neg_term_reg <= !cmd.term_feed;
        end

        if (cmd.load)
            acc_reg <= '0;
        else if (acc_en_reg)
            acc_reg <= neg_term_reg ? acc_reg - AW'(product_reg)
                                    : acc_reg + AW'(product_reg);

        if (cmd.prep)
        begin
            // quotient needs more than QW bits when the high part already reaches the divisor
            ovf_reg      <= (acc_mag[MW-1:QW] >= (MW - QW)'(d_mag));
            rem_reg      <= acc_mag[QW+DW-1:QW];
            quo_reg      <= acc_mag[QW-1:0];
            dmag_reg     <= d_mag;
            neg_q_reg    <= acc_reg[AW-1] ^ divisor[CW-1];
            zero_div_reg <= (divisor == '0);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
        end

        if (cmd.finish)
        begin
            sample_out_reg  <= y;
            saturated_reg   <= sat;
            bad_divisor_reg <= zero_div_reg;
        end
    end

    assign sample_out  = sample_out_reg;
    assign saturated   = saturated_reg;
    assign bad_divisor = bad_divisor_reg;

endmodule

`default_nettype wire

[rtl/iir_direct_form_one_filter_core.sv]
// Top level of the direct form I IIR filter core.
// Depends on iirdf1_pkg, iirdf1_regs, iirdf1_ctrl and iirdf1_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid / in_ready    | sample_in
//  output   | out_valid / out_ready  | sample_out, saturated, bad_divisor
//  config   | cfg_wr_en              | cfg_index, cfg_data
//
// A beat holds the core from acceptance until in_ready returns: 5 MAC slots on the
// shared 16x16 multiplier, one drain, one setup, 17 restoring divider steps and one
// finish step; the next beat is accepted only once the core is back in idle. The
// finish step loads the result register and raises out_valid. The result register
// frees the output side: a new beat is accepted while the previous result waits; the
// finish step holds until that result is taken. Reset is asynchronous, active low,
// and clears both histories and the sequencer state, but not the result register.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one_filter_core #(
    parameter int TAPS = 3
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [iirdf1_pkg::DATA_W-1:0]   sample_in,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [iirdf1_pkg::DATA_W-1:0]        sample_out,
    output logic                                        saturated,
    output logic                                        bad_divisor,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [iirdf1_pkg::COEF_W-1:0]          cfg_data
);

    iirdf1_pkg::cfg_t cfg;
    iirdf1_pkg::cmd_t cmd;

    iirdf1_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iirdf1_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    iirdf1_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sample_in   (sample_in),
        .sample_out  (sample_out),
        .saturated   (saturated),
        .bad_divisor (bad_divisor)
    );

endmodule

`default_nettype wire
